/* hdl/espmv_pkg.sv */
// Package for the ELLPACK sparse matrix-vector block: function codes,
// queue entry and queue status types. No dependencies.
`default_nettype none

package espmv_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_MAC   = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam int unsigned COL_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned Q_DEPTH = 4;

  typedef enum logic {
    OP_MAC,
    OP_START
  } espmv_op_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    espmv_op_t          op;
    logic               last;
    logic signed [31:0] mat;
    logic signed [31:0] vec;
  } espmv_entry_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } espmv_qstat_t;

endpackage

`default_nettype wire

/* hdl/espmv_front.sv */
// Front end: accepts items, keeps the dense-vector store, looks up the
// vector element of each matrix entry and pushes work to the queue.
// Depends on espmv_pkg.
`default_nettype none

module espmv_front #(
  parameter int VEC_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            func,
  input  wire logic [9:0]            column,
  input  wire logic signed [31:0]    element_value,
  input  wire logic                  last_in_row,
  input  wire espmv_pkg::espmv_qstat_t qstat,
  output logic                       push,
  output espmv_pkg::espmv_entry_t    push_entry
);
  import espmv_pkg::*;

  localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int CW = (AW > 10) ? AW : 10;

  logic signed [31:0] mem [VEC_DEPTH];

  logic [CW-1:0]      col_ext;
  logic [AW-1:0]      addr;
  logic               in_range;
  logic               accept;

  logic               s1_valid;
  espmv_op_t          s1_op;
  logic               s1_last;
  logic               s1_in_range;
  logic signed [31:0] s1_mat;
  logic signed [31:0] rd_data;

  assign col_ext  = CW'(column);
  assign addr     = col_ext[AW-1:0];
  assign in_range = {7'd0, column} < 17'(VEC_DEPTH);

  // one item may still sit in s1, so keep a spare slot
  assign in_ready = !qstat.almost_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_WRITE && in_range) begin
      mem[addr] <= element_value;
    end
    if (accept && func == FUNC_MAC) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (func == FUNC_MAC || func == FUNC_START);
    end
    s1_op       <= (func == FUNC_START) ? OP_START : OP_MAC;
    s1_last     <= last_in_row;
    s1_in_range <= in_range;
    s1_mat      <= element_value;
  end

  assign push            = s1_valid;
  assign push_entry.op   = s1_op;
  assign push_entry.last = s1_last;
  assign push_entry.mat  = s1_mat;
  // out-of-range column reads as zero
  assign push_entry.vec  = s1_in_range ? rd_data : 32'sd0;

endmodule

`default_nettype wire

/* hdl/espmv_queue.sv */
// Short FIFO between front and back end.
// Depends on espmv_pkg.
`default_nettype none

module espmv_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire espmv_pkg::espmv_entry_t push_entry,
  input  wire logic                   pop,
  output logic                        head_valid,
  output espmv_pkg::espmv_entry_t     head,
  output espmv_pkg::espmv_qstat_t     qstat
);
  import espmv_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  espmv_entry_t slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign do_push = push && (count != (PW+1)'(Q_DEPTH));
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  assign head_valid        = (count != '0);
  assign head              = slots[rd_ptr];
  assign qstat.full        = (count == (PW+1)'(Q_DEPTH));
  assign qstat.almost_full = (count >= (PW+1)'(Q_DEPTH - 1));

endmodule

`default_nettype wire

/* hdl/espmv_back.sv */
// Back end: multiply stage, saturating row accumulator, row counter and
// output register. Depends on espmv_pkg.
`default_nettype none

module espmv_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    head_valid,
  input  wire espmv_pkg::espmv_entry_t head,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [15:0]                  row_index,
  output logic signed [63:0]           row_sum
);
  import espmv_pkg::*;

  logic               p_valid;
  espmv_op_t          p_op;
  logic               p_last;
  logic signed [63:0] p_prod;
  logic signed [63:0] prod_c;

  logic signed [63:0] acc;
  logic [15:0]        row_cnt;
  logic signed [64:0] sum_wide;
  logic signed [63:0] sum_sat;
  logic               ovf;

  logic acc_go;
  logic p_load;

  assign prod_c = head.mat * head.vec;

  // a row end must wait for the output register to free up
  assign acc_go = p_valid && !(p_op == OP_MAC && p_last && out_valid && !out_ready);
  assign p_load = !p_valid || acc_go;
  assign pop    = head_valid && p_load;

  assign sum_wide = {acc[63], acc} + {p_prod[63], p_prod};
  assign ovf      = (acc[63] == p_prod[63]) && (sum_wide[63] != acc[63]);
  assign sum_sat  = !ovf ? sum_wide[63:0] :
                    (p_prod[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load) begin
      p_valid <= head_valid;
    end
    if (p_load) begin
      p_op   <= head.op;
      p_last <= head.last;
      p_prod <= prod_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      row_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (acc_go) begin
        unique case (p_op)
          OP_START: begin
            acc     <= '0;
            row_cnt <= '0;
          end
          OP_MAC: begin
            if (p_last) begin
              out_valid <= 1'b1;
              acc       <= '0;
              row_cnt   <= row_cnt + 16'd1;
            end else begin
              acc <= sum_sat;
            end
          end
          default: acc <= acc;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go && p_op == OP_MAC && p_last) begin
      row_index <= row_cnt;
      row_sum   <= sum_sat;
    end
  end

endmodule

`default_nettype wire

/* hdl/ellpack_sparse_matvec_top.sv */
// Top level of the ELLPACK/HLL sparse matrix times dense vector block.
// Depends on espmv_pkg, espmv_front, espmv_queue and espmv_back.
//
// Channel  Dir  Signals                    Carries
// s_*      in   tvalid tready tdata tuser  column, element_value, func,
//               tlast                      last_in_row
// m_*      out  tvalid tready tdata        row_index, row_sum
//
// One item per cycle sustained while the queue has room. A row sum is presented
// on m_* once its last entry has passed the vector store read, the queue and
// the multiply register, then been accumulated into the output register.
// The 64-bit saturating add into the row accumulator is the loop that
// sets the rate; the multiply sits in its own stage before it.
// Reset (rst, synchronous) clears row counter, accumulator, queue and
// valids; the vector store keeps its contents and is unknown until written.
// A stalled output holds the back end only once a row end is ready to
// leave; the 4-entry queue lets the front keep taking items until it is
// nearly full.
`default_nettype none

module ellpack_sparse_matvec_top #(
  parameter int VEC_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [9:0] column, [41:10] element_value, rest zero
  input  wire logic [1:0]  s_tuser,   // [1:0] func
  input  wire logic        s_tlast,   // last_in_row
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata    // [15:0] row_index, [79:16] row_sum
);
  import espmv_pkg::*;

  logic               q_push;
  espmv_entry_t       q_push_entry;
  logic               q_pop;
  logic               q_head_valid;
  espmv_entry_t       q_head;
  espmv_qstat_t       q_stat;
  logic [15:0]        row_index;
  logic signed [63:0] row_sum;

  espmv_front #(
    .VEC_DEPTH(VEC_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .func          (s_tuser),
    .column        (s_tdata[9:0]),
    .element_value (s_tdata[41:10]),
    .last_in_row   (s_tlast),
    .qstat         (q_stat),
    .push          (q_push),
    .push_entry    (q_push_entry)
  );

  espmv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .qstat      (q_stat)
  );

  espmv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .row_index  (row_index),
    .row_sum    (row_sum)
  );

  assign m_tdata = {row_sum, row_index};

  // front end credit must never let the queue overflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // back end only pops what is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("queue pop while empty");

  // a nearly full queue must hold off new items
  a_credit: assert property (@(posedge clk) disable iff (rst)
    q_stat.almost_full |-> !s_tready)
    else $error("input taken with no queue room");

endmodule

`default_nettype wire
